// File: hdl/gbfw_pkg.sv
// gbfw_pkg: types, constants and the control store of the breadth-first walk
// used by the channel interfaces, the top level and the checker
package gbfw_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 8;

  // fixed widths of the beat fields and registers
  localparam int unsigned ROW_INDEX_W = 3;
  localparam int unsigned ROW_BITS_W  = 8;
  localparam int unsigned VERTEX_W    = 3;
  localparam int unsigned VCOUNT_W    = 4;
  localparam int unsigned START_W     = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 4;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = VCOUNT_W'(8);
  localparam logic [START_W-1:0]  START_RST  = '0;

  localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_START_VERTEX = CFG_INDEX_W'(1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  localparam int unsigned STEP_W = 4;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_PUSH_START,
    OP_NOP,
    OP_TAKE,
    OP_CAND,
    OP_SCAN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_RUN_BEAT,
    C_BAD_START,
    C_CAND_EMPTY,
    C_OUT_FREE,
    C_QUEUE_LEFT
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             wait_cond;
    cond_e             jump_cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // control store: stay in a step until wait_cond holds, then jump to target
  // when jump_cond holds, else fall through to the next step
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      STEP_W'(0): w = '{OP_IDLE,       C_RUN_BEAT,   C_NEVER,      STEP_W'(0)};
      STEP_W'(1): w = '{OP_INIT,       C_ALWAYS,     C_BAD_START,  STEP_W'(0)};
      STEP_W'(2): w = '{OP_PUSH_START, C_ALWAYS,     C_NEVER,      STEP_W'(0)};
      STEP_W'(3): w = '{OP_NOP,        C_ALWAYS,     C_NEVER,      STEP_W'(0)};
      STEP_W'(4): w = '{OP_TAKE,       C_ALWAYS,     C_NEVER,      STEP_W'(0)};
      STEP_W'(5): w = '{OP_NOP,        C_ALWAYS,     C_NEVER,      STEP_W'(0)};
      STEP_W'(6): w = '{OP_CAND,       C_ALWAYS,     C_NEVER,      STEP_W'(0)};
      STEP_W'(7): w = '{OP_SCAN,       C_CAND_EMPTY, C_NEVER,      STEP_W'(0)};
      STEP_W'(8): w = '{OP_EMIT,       C_OUT_FREE,   C_QUEUE_LEFT, STEP_W'(3)};
      STEP_W'(9): w = '{OP_NOP,        C_ALWAYS,     C_ALWAYS,     STEP_W'(0)};
      default:    w = '{OP_NOP,        C_ALWAYS,     C_ALWAYS,     STEP_W'(0)};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/gbfw_if.sv
// gbfw_in_if, gbfw_out_if: valid/ready channels of the breadth-first walk
// depends on gbfw_pkg for the field widths
interface gbfw_in_if import gbfw_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [ROW_INDEX_W-1:0] row_index;
  logic [ROW_BITS_W-1:0]  row_bits;

  modport source (output valid, action, row_index, row_bits, input ready);
  modport sink   (input valid, action, row_index, row_bits, output ready);
endinterface

interface gbfw_out_if import gbfw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex;
  logic                last;

  modport source (output valid, vertex, last, input ready);
  modport sink   (input valid, vertex, last, output ready);
endinterface

// File: hdl/gbfw_ram.sv
// gbfw_ram: generic single write port memory with registered read
// no package dependency
module gbfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/graph_breadth_first_walk.sv
// graph_breadth_first_walk: breadth-first walk over an adjacency matrix
// depends on gbfw_pkg, gbfw_if (channels) and gbfw_ram (row store, vertex queue)
//
// A load beat (action 0) writes one adjacency row.
// A run beat (action 1) walks the graph from start_vertex and emits one result
// beat per reached vertex in breadth-first order, last set on the final one.
// A run steps through set-up, then per emitted vertex takes it from the queue,
// reads its row, scans the newly found neighbours and emits it, and ends with
// one closing step. The control sequencer walks one step per cycle while the
// step's wait condition holds; the queue and row memories have registered
// reads; the neighbour scan enqueues one vertex per cycle. Results leave through
// an output register, so a stalled sink only holds the walk at the emit step.
// The row store has no reset; rows must be loaded before a run reaches them.
// Configuration must be written only while idle; the block does not enforce it.
module graph_breadth_first_walk import gbfw_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  gbfw_in_if.sink                in_i,
  gbfw_out_if.source             out_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  logic [VCOUNT_W-1:0]     vcount_q;
  logic [START_W-1:0]      start_q;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [CW-1:0]           head_q, tail_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [MAX_VERTICES-1:0] cand_q;
  logic [VW-1:0]           v_q;
  logic                    out_valid_q;
  logic [VERTEX_W-1:0]     out_vertex_q;
  logic                    out_last_q;

  uword_t                  uw;
  logic                    run_beat, load_beat, row_ok, start_ok, out_free;
  logic                    wait_ok, jump_ok;
  logic                    push_en;
  logic [VW-1:0]           push_v;
  logic [VW-1:0]           first_v;
  logic [MAX_VERTICES-1:0] in_use;
  logic [VW-1:0]           q_rdata;
  logic [MAX_VERTICES-1:0] adj_rdata;

  assign uw = ucode_rom(step_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
      start_q  <= START_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VERTEX_COUNT: vcount_q <= cfg_data_i[VCOUNT_W-1:0];
        REG_START_VERTEX: start_q  <= cfg_data_i[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      in_use[i] = i < int'(vcount_q);
    end
  end

  always_comb begin
    first_v = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand_q[i]) begin
        first_v = VW'(i);
      end
    end
  end

  assign in_i.ready = (uw.op == OP_IDLE);
  assign run_beat   = in_i.valid && in_i.ready && (in_i.action == ACT_RUN);
  assign load_beat  = in_i.valid && in_i.ready && (in_i.action == ACT_LOAD);
  assign row_ok     = int'(in_i.row_index) < MAX_VERTICES;
  assign start_ok   = (int'(start_q) < int'(vcount_q)) && (int'(start_q) < MAX_VERTICES);
  assign out_free   = !out_valid_q || out_o.ready;

  function automatic logic cond_eval(input cond_e c, input logic run_b, input logic st_ok,
                                     input logic cand_empty, input logic o_free,
                                     input logic q_left);
    logic r;
    case (c)
      C_NEVER:      r = 1'b0;
      C_ALWAYS:     r = 1'b1;
      C_RUN_BEAT:   r = run_b;
      C_BAD_START:  r = !st_ok;
      C_CAND_EMPTY: r = cand_empty;
      C_OUT_FREE:   r = o_free;
      C_QUEUE_LEFT: r = q_left;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  // next step
  always_comb begin
    wait_ok = cond_eval(uw.wait_cond, run_beat, start_ok, cand_q == '0, out_free,
                        head_q != tail_q);
    jump_ok = cond_eval(uw.jump_cond, run_beat, start_ok, cand_q == '0, out_free,
                        head_q != tail_q);
    if (!wait_ok) begin
      step_d = step_q;
    end else if (jump_ok) begin
      step_d = uw.target;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // datapath controls
  always_comb begin
    push_en = 1'b0;
    push_v  = first_v;
    case (uw.op)
      OP_PUSH_START: begin
        push_en = 1'b1;
        push_v  = VW'(start_q);
      end
      OP_SCAN: push_en = cand_q != '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((uw.op == OP_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (uw.op)
        OP_INIT: begin
          head_q    <= '0;
          tail_q    <= '0;
          visited_q <= '0;
        end
        OP_TAKE: head_q <= head_q + CW'(1);
        default: ;
      endcase
      if (push_en) begin
        if (tail_q < CW'(MAX_VERTICES)) begin
          tail_q <= tail_q + CW'(1);
        end
        visited_q <= visited_q | (MAX_VERTICES'(1) << push_v);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_TAKE: v_q <= q_rdata;
      OP_CAND: cand_q <= adj_rdata & in_use & ~visited_q;
      OP_SCAN: cand_q <= cand_q & (cand_q - MAX_VERTICES'(1));
      OP_EMIT: begin
        if (out_free) begin
          out_vertex_q <= VERTEX_W'(v_q);
          out_last_q   <= head_q == tail_q;
        end
      end
      default: ;
    endcase
  end

  gbfw_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (push_en && (tail_q < CW'(MAX_VERTICES))),
    .waddr_i (tail_q[VW-1:0]),
    .wdata_i (push_v),
    .raddr_i (head_q[VW-1:0]),
    .rdata_o (q_rdata)
  );

  gbfw_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (load_beat && row_ok),
    .waddr_i (VW'(in_i.row_index)),
    .wdata_i (MAX_VERTICES'(in_i.row_bits)),
    .raddr_i (v_q),
    .rdata_o (adj_rdata)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.vertex = out_vertex_q;
  assign out_o.last   = out_last_q;

endmodule

// File: hdl/gbfw_checker.sv
// gbfw_checker: port-level assertions for the breadth-first walk, and its bind
// depends on gbfw_pkg and binds to graph_breadth_first_walk
module gbfw_checker import gbfw_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_action_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [VERTEX_W-1:0] out_vertex_i,
  input logic                out_last_i
);

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_vertex_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // a run beat leaves the input closed right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_RUN) |=> !in_ready_i)
    else $error("input open right after a run beat");

  // an offered result beat carries known fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown({out_vertex_i, out_last_i}))
    else $error("result beat offered with unknown fields");

endmodule

bind graph_breadth_first_walk gbfw_checker u_gbfw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_action_i  (in_i.action),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_vertex_i (out_o.vertex),
  .out_last_i   (out_o.last)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for graph_breadth_first_walk, directed table then random phases
// depends on gbfw_pkg, gbfw_if and the top level; predicts visit order per run beat
module tb;
  import gbfw_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned NUM_PHASES    = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  typedef enum logic [1:0] {
    STEP_LOAD,
    STEP_RUN,
    STEP_WRITE
  } step_kind_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [ROW_INDEX_W-1:0] row;
    logic [ROW_BITS_W-1:0]  bits;
    logic                   typed_on;
    logic [3:0]             n_typed;
    logic [31:0]            typed_seq;
  } dir_step_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
  } visit_t;

  localparam int unsigned NUM_DIR = 39;
  // typed sequences: one nibble per vertex, first visited in the top nibble
  localparam dir_step_t SCRIPT [NUM_DIR] = '{
    '{STEP_LOAD,  '0, 3'd0, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd1, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd2, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd3, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd4, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd5, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd6, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd7, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b1, 4'd1, 32'h0000_0000},
    '{STEP_LOAD,  '0, 3'd0, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd1, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd2, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd3, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd4, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd5, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd6, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd7, 8'hFF, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b1, 4'd8, 32'h0123_4567},
    '{STEP_WRITE, REG_START_VERTEX, 3'd0, 8'h07, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd7, 8'hFF, 1'b1, 4'd8, 32'h7012_3456},
    '{STEP_WRITE, REG_VERTEX_COUNT, 3'd0, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b1, 4'd0, 32'h0},
    '{STEP_WRITE, REG_VERTEX_COUNT, 3'd0, 8'h0F, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b1, 4'd8, 32'h7012_3456},
    '{STEP_WRITE, REG_VERTEX_COUNT, 3'd0, 8'h05, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b1, 4'd0, 32'h0},
    '{STEP_WRITE, REG_START_VERTEX, 3'd0, 8'h04, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b1, 4'd5, 32'h4012_3000},
    '{STEP_WRITE, REG_SPARE_A,      3'd0, 8'h0F, 1'b0, 4'd0, 32'h0},
    '{STEP_WRITE, REG_SPARE_B,      3'd0, 8'h0A, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b1, 4'd5, 32'h4012_3000},
    '{STEP_WRITE, REG_VERTEX_COUNT, 3'd0, 8'h08, 1'b0, 4'd0, 32'h0},
    '{STEP_WRITE, REG_START_VERTEX, 3'd0, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd0, 8'h24, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd2, 8'h81, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd0, 8'h00, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd7, 8'h80, 1'b0, 4'd0, 32'h0},
    '{STEP_LOAD,  '0, 3'd5, 8'h01, 1'b0, 4'd0, 32'h0},
    '{STEP_RUN,   '0, 3'd5, 8'h5A, 1'b0, 4'd0, 32'h0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gbfw_in_if  in_if ();
  gbfw_out_if out_if ();

  graph_breadth_first_walk u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // predictor state
  logic [ROW_BITS_W-1:0] adj_rows_model [MAX_VERTICES_DEF];
  logic [VCOUNT_W-1:0]   mirror_vcount;
  logic [START_W-1:0]    mirror_start;
  visit_t                expected_visits [$];

  logic        pend_typed;
  logic [3:0]  pend_count;
  logic [31:0] pend_seq;
  logic        idle_on;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  visit_t      want;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic predict_walk();
    int unsigned n;
    int unsigned head;
    int unsigned tail;
    int unsigned i;
    logic [MAX_VERTICES_DEF-1:0] in_use;
    logic [MAX_VERTICES_DEF-1:0] seen;
    logic [MAX_VERTICES_DEF-1:0] cand;
    logic [VERTEX_W-1:0]         fifo [MAX_VERTICES_DEF];
    logic [VERTEX_W-1:0]         v;
    n = (mirror_vcount > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : mirror_vcount;
    if (n == 0 || mirror_start >= n) return;
    in_use = '0;
    for (i = 0; i < n; i++) in_use[i] = 1'b1;
    seen = '0;
    seen[mirror_start] = 1'b1;
    fifo[0] = mirror_start;
    head = 0;
    tail = 1;
    while (head < tail) begin
      v = fifo[head];
      head++;
      cand = adj_rows_model[v] & in_use & ~seen;
      for (i = 0; i < n; i++) begin
        if (cand[i]) begin
          fifo[tail] = VERTEX_W'(i);
          tail++;
          seen[i] = 1'b1;
        end
      end
      expected_visits.push_back('{v, head == tail});
    end
  endtask

  // scoreboard: update the row model on load beats, predict on run beats, compare every output beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        if (in_if.action == ACT_LOAD) begin
          adj_rows_model[in_if.row_index] = in_if.row_bits;
        end else if (pend_typed) begin
          for (int k = 0; k < pend_count; k++)
            expected_visits.push_back('{pend_seq[28-4*k +: 3], k == pend_count - 1});
        end else begin
          predict_walk();
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_visits.size() == 0) begin
          report_mismatch($sformatf("vertex %0d with nothing expected", out_if.vertex));
        end else begin
          want = expected_visits.pop_front();
          if (out_if.vertex !== want.vertex)
            report_mismatch($sformatf("vertex %0d, expected %0d", out_if.vertex, want.vertex));
          if (out_if.last !== want.last)
            report_mismatch($sformatf("last %0b on vertex %0d, expected %0b",
                                      out_if.last, out_if.vertex, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // sink side: ready held in random bursts, or held high when idle_on is clear
  initial begin
    int unsigned len;
    logic        val;
    out_if.ready = 1'b0;
    forever begin
      if (idle_on) begin
        len = $urandom_range(1, 16);
        val = ($urandom_range(0, 2) != 0);
      end else begin
        len = 1;
        val = 1'b1;
      end
      repeat (len) begin
        @(negedge clk_i);
        out_if.ready <= val;
      end
    end
  end

  task automatic send_beat(input logic act, input logic [ROW_INDEX_W-1:0] row,
                           input logic [ROW_BITS_W-1:0] bits, input logic typed_on,
                           input logic [3:0] n_typed, input logic [31:0] typed_seq);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pend_typed = typed_on;
    pend_count = n_typed;
    pend_seq   = typed_seq;
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.row_index <= row;
    in_if.row_bits  <= bits;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_for_visits();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_block();
    wait_for_visits();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    case (idx)
      REG_VERTEX_COUNT: mirror_vcount = val;
      REG_START_VERTEX: mirror_start  = val[START_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ROW_BITS_W-1:0] pick_row_bits();
    logic [ROW_BITS_W-1:0] b;
    case ($urandom_range(0, 4))
      0:       b = ROW_BITS_W'($urandom & $urandom);
      1:       b = '0;
      2:       b = '1;
      3:       b = ROW_BITS_W'(1) << $urandom_range(0, ROW_BITS_W - 1);
      default: b = ROW_BITS_W'($urandom);
    endcase
    return b;
  endfunction

  initial begin
    int unsigned vc;
    int unsigned st;
    int unsigned n_items;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_LOAD;
    in_if.row_index = '0;
    in_if.row_bits  = '0;
    pend_typed      = 1'b0;
    pend_count      = '0;
    pend_seq        = '0;
    idle_on         = 1'b1;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    mirror_vcount   = VCOUNT_RST;
    mirror_start    = START_RST;
    foreach (adj_rows_model[i]) adj_rows_model[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == STEP_WRITE) begin
        settle_block();
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].bits[CFG_DATA_W-1:0]);
      end else begin
        send_beat(SCRIPT[i].kind == STEP_RUN ? ACT_RUN : ACT_LOAD, SCRIPT[i].row,
                  SCRIPT[i].bits, SCRIPT[i].typed_on, SCRIPT[i].n_typed,
                  SCRIPT[i].typed_seq);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin vc = 8;  st = 0; end
        1: begin vc = 1;  st = 0; end
        2: begin vc = 15; st = 7; end
        3: begin vc = 0;  st = $urandom_range(0, 7); end
        default: begin
          vc = $urandom_range(1, 8);
          st = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(0, vc - 1);
        end
      endcase
      settle_block();
      write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(vc));
      write_reg(REG_START_VERTEX, CFG_DATA_W'(st));
      idle_on = (phase != NUM_PHASES - 1);
      n_items = (phase == 3) ? 20 : 55;
      for (int k = 0; k < n_items; k++) begin
        if (phase == 5 && k == 27) wait_for_visits();
        send_beat(($urandom_range(0, 99) < 35) ? ACT_RUN : ACT_LOAD,
                  ROW_INDEX_W'($urandom), pick_row_bits(), 1'b0, 4'd0, 32'h0);
      end
    end

    settle_block();
    if (expected_visits.size() != 0)
      report_mismatch($sformatf("%0d vertices never arrived", expected_visits.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/gbfw_pkg.sv
hdl/gbfw_if.sv
hdl/gbfw_ram.sv
hdl/graph_breadth_first_walk.sv
hdl/gbfw_checker.sv
tb/sv/tb.sv
